>>> sv/olad_pkg.sv
// Package for the ordered list block: sizes, op and status codes,
// item structs and the control struct shared by the top level and the cells.
// No dependencies.
package olad_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    localparam logic [2:0] ST_DONE     = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_ENTRY    = 3'd4;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        logic [2:0]         status;
        logic [4:0]         position;
        logic signed [31:0] entry_value;
        logic [4:0]         entry_count;
        logic               last;
    } t_out;

    typedef enum logic [1:0] {
        CMD_HOLD  = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_SHIFT = 2'd2,
        CMD_ROT   = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd               cmd;
        logic signed [31:0] value;
    } t_cell_ctrl;

endpackage

>>> sv/olad_cell.sv
// One list cell: holds one entry, loads it on append, compares it for delete,
// and takes its neighbor's entry on shift or rotate. Depends on olad_pkg.
module olad_cell (
    input  logic                   i_clk,
    input  olad_pkg::t_cell_ctrl   i_ctrl,
    input  logic                   i_sel,
    input  logic                   i_live,
    input  logic                   i_hit_in,
    input  logic signed [31:0]     i_next,
    output logic                   o_hit,
    output logic signed [31:0]     o_val
);
    import olad_pkg::*;

    logic signed [31:0] r_val;
    logic signed [31:0] n_val;

    assign o_hit = i_hit_in | (i_live && (r_val == i_ctrl.value));
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        case (i_ctrl.cmd)
            CMD_LOAD: begin
                if (i_sel) begin
                    n_val = i_ctrl.value;
                end
            end
            CMD_SHIFT: begin
                if (o_hit) begin
                    n_val = i_next;
                end
            end
            CMD_ROT: begin
                n_val = i_next;
            end
            default: begin
                n_val = r_val;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

>>> sv/ordered_list_append_delete.sv
// Top level of the ordered list: control sequencer, entry count and the
// row of olad_cell instances. Depends on olad_pkg and olad_cell.
//
// Usage:
//   An item (op, value) is taken at a clock edge with start high and busy low.
//   Append puts value at the tail; delete removes the first equal entry and
//   closes the gap; readout emits every entry in order from position 1.
//   Each result shows on o_result for one cycle with o_strobe high; the
//   receiver always takes it. last marks the final result of an item.
// Timing:
//   Append and delete register the item, then do the parallel compare
//   and shift across the cells; the result is on the ports in the cycle
//   after that and the next item may be taken at the edge that ends it.
//   Op 3 gives no result. Readout rotates the list through the cell row
//   one entry per cycle and the head cell feeds the output; entries come
//   out on back-to-back cycles.
// Reset:
//   Synchronous, active low; the list is empty afterwards. Cell contents are
//   not cleared; only entries below the count are ever read.
module ordered_list_append_delete (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  olad_pkg::t_in   i_item,
    output logic            o_strobe,
    output olad_pkg::t_out  o_result
);
    import olad_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_READ = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [1:0]         r_op;
    logic signed [31:0] r_value;
    logic               r_strobe, n_strobe;
    t_out               r_result, n_result;

    t_cell_ctrl         w_ctrl;
    logic               w_hit [0:CAPACITY];
    logic signed [31:0] w_val [0:CAPACITY-1];
    logic               w_accept;
    logic               w_read_last;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign o_strobe = r_strobe;
    assign o_result = r_result;
    assign w_hit[0] = 1'b0;

    assign w_read_last = ({1'b0, r_idx} + CNT_W'(1)) == r_count;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic signed [31:0] w_next;
            if (g == CAPACITY - 1) begin : g_tail
                assign w_next = w_val[0];
            end else begin : g_mid
                assign w_next = (r_count == CNT_W'(g + 1)) ? w_val[0] : w_val[g + 1];
            end
            olad_cell u_cell (
                .i_clk    (i_clk),
                .i_ctrl   (w_ctrl),
                .i_sel    (r_count == CNT_W'(g)),
                .i_live   (r_count > CNT_W'(g)),
                .i_hit_in (w_hit[g]),
                .i_next   (w_next),
                .o_hit    (w_hit[g + 1]),
                .o_val    (w_val[g])
            );
        end
    endgenerate

    always_comb begin
        n_state        = r_state;
        n_count        = r_count;
        n_idx          = r_idx;
        n_strobe       = 1'b0;
        n_result       = r_result;
        w_ctrl.cmd     = CMD_HOLD;
        w_ctrl.value   = r_value;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state                = S_IDLE;
                n_result.position      = '0;
                n_result.entry_value   = '0;
                n_result.entry_count   = 5'(r_count);
                n_result.last          = 1'b1;
                n_result.status        = ST_DONE;
                case (r_op)
                    OP_APPEND: begin
                        n_strobe = 1'b1;
                        if (r_count == CNT_W'(CAPACITY)) begin
                            n_result.status = ST_FULL;
                        end else begin
                            w_ctrl.cmd           = CMD_LOAD;
                            n_count              = r_count + CNT_W'(1);
                            n_result.entry_count = 5'(r_count + CNT_W'(1));
                        end
                    end
                    OP_DELETE: begin
                        n_strobe = 1'b1;
                        if (r_count == '0) begin
                            n_result.status = ST_EMPTY;
                        end else if (w_hit[CAPACITY]) begin
                            w_ctrl.cmd           = CMD_SHIFT;
                            n_count              = r_count - CNT_W'(1);
                            n_result.entry_count = 5'(r_count - CNT_W'(1));
                        end else begin
                            n_result.status = ST_NOTFOUND;
                        end
                    end
                    OP_READ: begin
                        if (r_count == '0) begin
                            n_strobe        = 1'b1;
                            n_result.status = ST_EMPTY;
                        end else begin
                            n_state = S_READ;
                            n_idx   = '0;
                        end
                    end
                    default: begin
                        n_strobe = 1'b0;
                    end
                endcase
            end
            S_READ: begin
                w_ctrl.cmd           = CMD_ROT;
                n_strobe             = 1'b1;
                n_result.status      = ST_ENTRY;
                n_result.position    = 5'({1'b0, r_idx} + CNT_W'(1));
                n_result.entry_value = w_val[0];
                n_result.entry_count = 5'(r_count);
                n_result.last        = w_read_last;
                n_idx                = r_idx + IDX_W'(1);
                if (w_read_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_idx    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        if (w_accept) begin
            r_op    <= i_item.op;
            r_value <= i_item.value;
        end
    end

`ifndef SYNTHESIS
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result without an item in progress");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last) |-> !busy)
        else $error("still busy after final result");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("accepted item did not start");

    a_read_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last) |-> (busy && o_result.status == ST_ENTRY))
        else $error("non-final result outside readout");
`endif

endmodule
